@@ hw/rtl/lru_key_value_cache_assert.svh @@
// Assertion macros used by the cache controller RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef ASSERT_OFF

`define LKV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkv assertion failed");

`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkv assertion failed");

`else

`define LKV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/lkv_pkg.sv @@
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 16;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam int S_DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * VALUE_BITS + 7) / 8) * 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
    localparam logic             REG_CAPACITY   = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic                  rank_we;
        logic [IDX_W-1:0]      rank_addr;
        logic [IDX_W-1:0]      rank_data;
        logic                  key_we;
        logic                  value_we;
        logic [IDX_W-1:0]      slot;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } store_wr_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      rank;
    } store_rd_t;

endpackage

@@ hw/rtl/lkv_store.sv @@
module lkv_store
#(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lkv_ctrl.sv @@
`include "lru_key_value_cache_assert.svh"

module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CAP_W-1:0]      capacity,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_mode,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_hit,
    output logic [VALUE_BITS-1:0] out_read_value,
    output logic                  out_evicted,
    output logic [VALUE_BITS-1:0] out_evicted_value,
    output store_wr_t             wr,
    output logic [IDX_W-1:0]      rd_addr,
    input  store_rd_t             rd
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      used_count_reg, used_count_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  mode_reg, mode_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      match_rank_reg, match_rank_next;
    logic [IDX_W-1:0]      match_idx_reg, match_idx_next;
    logic [VALUE_BITS-1:0] match_value_reg, match_value_next;
    logic [IDX_W-1:0]      worst_idx_reg, worst_idx_next;
    logic [IDX_W-1:0]      worst_rank_reg, worst_rank_next;
    logic [VALUE_BITS-1:0] worst_value_reg, worst_value_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      old_rank_reg, old_rank_next;
    logic                  insert_reg, insert_next;
    logic                  out_hit_reg, out_hit_next;
    logic [VALUE_BITS-1:0] out_rd_reg, out_rd_next;
    logic                  out_ev_reg, out_ev_next;
    logic [VALUE_BITS-1:0] out_evv_reg, out_evv_next;

    logic [IDX_W-1:0]      idx_cur;
    logic                  scan_done;
    logic                  out_free;
    logic [CAP_W-1:0]      cap_eff;
    logic                  room;

    assign idx_cur   = idx_reg[IDX_W-1:0];
    assign scan_done = (idx_reg == used_count_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign cap_eff   = (capacity == '0) ? CAP_W'(1) : capacity;
    assign room      = (CMP_W'(used_count_reg) < CMP_W'(ENTRIES))
                    && (CMP_W'(used_count_reg) < CMP_W'(cap_eff));

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_addr  = idx_next[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        used_count_next  = used_count_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        found_next       = found_reg;
        match_rank_next  = match_rank_reg;
        match_idx_next   = match_idx_reg;
        match_value_next = match_value_reg;
        worst_idx_next   = worst_idx_reg;
        worst_rank_next  = worst_rank_reg;
        worst_value_next = worst_value_reg;
        slot_next        = slot_reg;
        old_rank_next    = old_rank_reg;
        insert_next      = insert_reg;
        out_hit_next     = out_hit_reg;
        out_rd_next      = out_rd_reg;
        out_ev_next      = out_ev_reg;
        out_evv_next     = out_evv_reg;

        wr           = '0;
        wr.rank_addr = idx_cur;
        wr.slot      = slot_reg;
        wr.key       = key_reg;
        wr.value     = value_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    key_next   = in_key;
                    value_next = in_value;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    if (!found_reg && (rd.key == key_reg))
                    begin
                        found_next       = 1'b1;
                        match_idx_next   = idx_cur;
                        match_rank_next  = rd.rank;
                        match_value_next = rd.value;
                    end
                    if ((idx_reg == '0) || (rd.rank > worst_rank_reg))
                    begin
                        worst_idx_next   = idx_cur;
                        worst_rank_next  = rd.rank;
                        worst_value_next = rd.value;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DECIDE:
            begin
                insert_next = 1'b0;
                if (found_reg)
                begin
                    slot_next     = match_idx_reg;
                    old_rank_next = match_rank_reg;
                end
                else if (room)
                begin
                    insert_next   = 1'b1;
                    slot_next     = used_count_reg[IDX_W-1:0];
                    old_rank_next = used_count_reg[IDX_W-1:0];
                end
                else
                begin
                    slot_next     = worst_idx_reg;
                    old_rank_next = worst_rank_reg;
                end
                idx_next   = '0;
                state_next = (found_reg || mode_reg) ? ST_UPDATE : ST_FINISH;
            end
            ST_UPDATE:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // age every entry more recent than the one being promoted
                    if ((idx_cur != slot_reg) && (insert_reg || (rd.rank < old_rank_reg)))
                    begin
                        wr.rank_we   = 1'b1;
                        wr.rank_data = rd.rank + IDX_W'(1);
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    wr.rank_we   = found_reg || mode_reg;
                    wr.rank_addr = slot_reg;
                    wr.rank_data = '0;
                    wr.value_we  = mode_reg;
                    wr.key_we    = mode_reg && !found_reg;
                    if (mode_reg && !found_reg && insert_reg)
                    begin
                        used_count_next = used_count_reg + CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_rd_next    = (found_reg && !mode_reg) ? match_value_reg : '0;
                    out_ev_next    = mode_reg && !found_reg && !insert_reg;
                    out_evv_next   = (mode_reg && !found_reg && !insert_reg)
                                   ? worst_value_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        found_reg       <= found_next;
        match_rank_reg  <= match_rank_next;
        match_idx_reg   <= match_idx_next;
        match_value_reg <= match_value_next;
        worst_idx_reg   <= worst_idx_next;
        worst_rank_reg  <= worst_rank_next;
        worst_value_reg <= worst_value_next;
        slot_reg        <= slot_next;
        old_rank_reg    <= old_rank_next;
        insert_reg      <= insert_next;
        out_hit_reg     <= out_hit_next;
        out_rd_reg      <= out_rd_next;
        out_ev_reg      <= out_ev_next;
        out_evv_reg     <= out_evv_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_hit           = out_hit_reg;
    assign out_read_value    = out_rd_reg;
    assign out_evicted       = out_ev_reg;
    assign out_evicted_value = out_evv_reg;

    `LKV_ASSERT_IMPLIES(a_used_bound, clk, rst_n, 1'b1, used_count_reg <= CNT_W'(ENTRIES))
    `LKV_ASSERT_IMPLIES(a_used_step, clk, rst_n, used_count_reg != $past(used_count_reg), used_count_reg == $past(used_count_reg) + CNT_W'(1))
    `LKV_ASSERT_IMPLIES(a_result_from_finish, clk, rst_n, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == ST_FINISH)
    `LKV_ASSERT_IMPLIES(a_evict_is_miss, clk, rst_n, out_valid_reg && out_ev_reg, !out_hit_reg)
    `LKV_ASSERT_IMPLIES(a_read_needs_hit, clk, rst_n, out_valid_reg && (out_rd_reg != '0), out_hit_reg && !out_ev_reg)

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// Each item makes one search pass over the entries in use and, unless it is a get that
// misses, one rank pass; one entry a cycle. A new item is accepted only once the
// controller is idle again; a result waiting in the output register does not block
// the scan of the next item.
// Reset: used count cleared, capacity set to 16; entry storage is not cleared.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key, value
    input  logic [0:0]          s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // read_value, evicted_value
    output logic [1:0]          m_tuser    // hit, evicted
);

    logic [CAP_W-1:0]      capacity_reg;
    store_wr_t             wr;
    store_rd_t             rd;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IDX_W-1:0]      rd_rank;
    logic                  out_hit;
    logic                  out_evicted;
    logic [VALUE_BITS-1:0] out_read_value;
    logic [VALUE_BITS-1:0] out_evicted_value;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    lkv_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .capacity          (capacity_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_mode           (s_tuser[0]),
        .in_key            (s_tdata[KEY_BITS-1:0]),
        .in_value          (s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_hit           (out_hit),
        .out_read_value    (out_read_value),
        .out_evicted       (out_evicted),
        .out_evicted_value (out_evicted_value),
        .wr                (wr),
        .rd_addr           (rd_addr),
        .rd                (rd)
    );

    lkv_store #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr.key_we),
        .waddr (wr.slot),
        .wdata (wr.key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    lkv_store #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (wr.value_we),
        .waddr (wr.slot),
        .wdata (wr.value),
        .raddr (rd_addr),
        .rdata (rd_value)
    );

    lkv_store #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (wr.rank_we),
        .waddr (wr.rank_addr),
        .wdata (wr.rank_data),
        .raddr (rd_addr),
        .rdata (rd_rank)
    );

    assign rd = {rd_key, rd_value, rd_rank};

    assign m_tdata = M_DATA_W'({out_evicted_value, out_read_value});
    assign m_tuser = {out_evicted, out_hit};

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lkv_pkg::*;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;
    localparam int   QUIET_LIMIT = 4000;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   SETTLE_CYCLES = 60;

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cache_request_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [VALUE_BITS-1:0] evicted_value;
    } cache_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // key, value
    logic [0:0]          s_tuser = '0;   // mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // read_value, evicted_value
    logic [1:0]          m_tuser;        // hit, evicted

    lru_key_value_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Cache shadow state
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value [ENTRIES];
    int unsigned           slot_rank  [ENTRIES];
    int unsigned           slots_used = 0;
    logic [CAP_W-1:0]      capacity_setting = CAPACITY_RESET;

    cache_request_t pending_requests[$];
    cache_reply_t   expected_replies[$];
    cache_request_t offered_request;
    cache_reply_t   oldest_reply;
    int unsigned    send_gap = 0;
    int unsigned    stall_left = 0;
    int unsigned    hold_left = 0;
    int unsigned    hold_request = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    mismatch_count = 0;
    bit             idling_on = 1'b1;

    function automatic void promote_slot(int unsigned s);
        int unsigned old_rank;
        old_rank = slot_rank[s];
        for (int unsigned i = 0; i < slots_used; i++)
            if (i != s && slot_rank[i] < old_rank)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic cache_reply_t apply_request(cache_request_t req);
        cache_reply_t r;
        int           found;
        int unsigned  worst;
        int unsigned  limit;
        r = '0;
        found = -1;
        for (int unsigned i = 0; i < slots_used; i++)
            if (found < 0 && slot_key[i] == req.key)
                found = int'(i);
        if (found >= 0) begin
            r.hit = 1'b1;
            if (req.mode == MODE_GET)
                r.read_value = slot_value[found];
            else
                slot_value[found] = req.value;
            promote_slot(unsigned'(found));
        end else if (req.mode == MODE_PUT) begin
            if (capacity_setting == 0)
                limit = 1;
            else if (capacity_setting > ENTRIES)
                limit = ENTRIES;
            else
                limit = 32'(capacity_setting);
            if (slots_used < limit) begin
                for (int unsigned i = 0; i < slots_used; i++)
                    slot_rank[i]++;
                slot_key[slots_used] = req.key;
                slot_value[slots_used] = req.value;
                slot_rank[slots_used] = 0;
                slots_used++;
            end else begin
                worst = 0;
                for (int unsigned i = 1; i < slots_used; i++)
                    if (slot_rank[i] > slot_rank[worst])
                        worst = i;
                r.evicted = 1'b1;
                r.evicted_value = slot_value[worst];
                slot_key[worst] = req.key;
                slot_value[worst] = req.value;
                promote_slot(worst);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_request(offered_request));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0 && idling_on
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 4) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    offered_request = pending_requests.pop_front();
                    s_tdata  <= S_DATA_W'({offered_request.value, offered_request.key});
                    s_tuser  <= offered_request.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor and receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected item", {m_tuser, m_tdata[29:0]}, 0);
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (m_tuser[0] !== oldest_reply.hit)
                        report_mismatch("hit", 32'(m_tuser[0]), 32'(oldest_reply.hit));
                    if (m_tdata[VALUE_BITS-1:0] !== oldest_reply.read_value)
                        report_mismatch("read_value", 32'(m_tdata[VALUE_BITS-1:0]),
                                        32'(oldest_reply.read_value));
                    if (m_tuser[1] !== oldest_reply.evicted)
                        report_mismatch("evicted", 32'(m_tuser[1]),
                                        32'(oldest_reply.evicted));
                    if (m_tdata[2*VALUE_BITS-1:VALUE_BITS] !== oldest_reply.evicted_value)
                        report_mismatch("evicted_value",
                                        32'(m_tdata[2*VALUE_BITS-1:VALUE_BITS]),
                                        32'(oldest_reply.evicted_value));
                end
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no progress", $realtime);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_capacity(input logic [PDATA_W-1:0] cap);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_CAPACITY);
        pwdata  <= cap;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_setting = cap[CAP_W-1:0];
        @(negedge clk);
    endtask

    task automatic queue_request(input logic mode, input logic [KEY_BITS-1:0] key,
                                 input logic [VALUE_BITS-1:0] value);
        cache_request_t req;
        req.mode = mode;
        req.key = key;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    // Mostly keys from a small pool so gets hit and puts update; some fresh keys.
    task automatic run_random_phase(input logic [PDATA_W-1:0] cap, input int unsigned count,
                                    input int unsigned pool_size, input bit with_hold);
        logic [KEY_BITS-1:0] key_pool[$];
        logic [KEY_BITS-1:0] key;
        write_capacity(cap);
        for (int unsigned i = 0; i < pool_size; i++)
            key_pool.push_back($urandom);
        if (with_hold)
            hold_request = HOLD_OFF_CYCLES;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            queue_request($urandom_range(0, 1) ? MODE_PUT : MODE_GET, key,
                          VALUE_BITS'($urandom));
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty cache, extreme keys and values, update in place
        queue_request(MODE_GET, 32'h0000_0000, 16'hFFFF);
        queue_request(MODE_PUT, 32'h0000_0000, 16'h0000);
        queue_request(MODE_PUT, 32'hFFFF_FFFF, 16'hFFFF);
        queue_request(MODE_GET, 32'h0000_0000, 16'h1111);
        queue_request(MODE_GET, 32'hFFFF_FFFF, 16'h0000);
        queue_request(MODE_PUT, 32'h0000_0000, 16'h1234);
        queue_request(MODE_GET, 32'h1234_5678, 16'h0000);
        queue_request(MODE_PUT, 32'h8000_0001, 16'h8001);
        wait_for_drain();

        // Capacity below the entries in use
        write_capacity(2);
        queue_request(MODE_PUT, 32'h5555_5555, 16'h5555);
        queue_request(MODE_PUT, 32'hAAAA_AAAA, 16'hAAAA);
        queue_request(MODE_GET, 32'h5555_5555, 16'h0000);
        queue_request(MODE_PUT, 32'h0000_0007, 16'h0007);
        wait_for_drain();

        // Capacity zero acts as one
        write_capacity(0);
        queue_request(MODE_PUT, 32'h0000_0009, 16'h0009);
        queue_request(MODE_GET, 32'h0000_0009, 16'h0000);
        queue_request(MODE_PUT, 32'h7FFF_FFFE, 16'h7FFE);
        wait_for_drain();

        run_random_phase(31, 90, 22, 1'b0);
        run_random_phase(1, 60, 3, 1'b0);
        run_random_phase(5, 80, 8, 1'b1);
        run_random_phase(0, 50, 3, 1'b0);
        run_random_phase(16, 90, 20, 1'b0);
        run_random_phase(3, 70, 5, 1'b0);
        run_random_phase(12, 80, 16, 1'b0);
        idling_on = 1'b0;
        run_random_phase(16, 100, 24, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
